// ===== src/utf8_text_width_measurer_top_defines.svh =====
`ifndef UTF8_TEXT_WIDTH_MEASURER_TOP_DEFINES_SVH
`define UTF8_TEXT_WIDTH_MEASURER_TOP_DEFINES_SVH

// same-cycle implication
`define UTWM_ASSERT_NOW(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
        else $error(MSG);

// next-cycle implication
`define UTWM_ASSERT_NEXT(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== src/utwm_pkg.sv =====
package utwm_pkg;

    localparam int MAX_GLYPHS_DEF = 1024;
    localparam int WIDTH_BITS_DEF = 16;

    localparam int CMD_W        = 2;
    localparam int INDEX_W      = 10;
    localparam int CP_W         = 21;
    localparam int ADV_W        = 8;
    localparam int BYTE_W       = 8;
    localparam int TEXT_W       = 16;
    localparam int COUNT_W      = 11;
    localparam int ENTRY_W      = CP_W + ADV_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    localparam logic [CP_W-1:0]   REPLACEMENT_CP   = 21'h00FFFD;
    localparam logic [ADV_W-1:0]  FALLBACK_RESET   = 8'd4;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_BYTE = 2'd1,
        CMD_END  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_COUNT = 2'd0,
        CFG_FALLBACK    = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_WAIT,
        CTL_LEAD,
        CTL_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        SRCH_IDLE,
        SRCH_PROBE,
        SRCH_MISS
    } srch_state_t;

    typedef struct packed {
        logic            start;
        logic [CP_W-1:0] codepoint;
    } srch_req_t;

    typedef struct packed {
        logic             done;
        logic [ADV_W-1:0] advance;
    } srch_rsp_t;

endpackage

// ===== src/utwm_if.sv =====
interface utwm_item_if;
    import utwm_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [INDEX_W-1:0]  entry_index;
    logic [CP_W-1:0]     entry_codepoint;
    logic [ADV_W-1:0]    entry_advance;
    logic [BYTE_W-1:0]   text_byte;

    modport source (
        output valid, command, entry_index, entry_codepoint, entry_advance, text_byte,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_codepoint, entry_advance, text_byte,
        output ready
    );
endinterface

interface utwm_result_if;
    import utwm_pkg::*;

    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_width;
    logic              width_saturated;

    modport source (output valid, text_width, width_saturated, input ready);
    modport sink   (input valid, text_width, width_saturated, output ready);
endinterface

interface utwm_cfg_if;
    import utwm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/utwm_ram.sv =====
module utwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/utwm_search.sv =====
module utwm_search #(
    parameter int MAX_GLYPHS = utwm_pkg::MAX_GLYPHS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  utwm_pkg::srch_req_t                                 req,
    input  logic [$clog2(MAX_GLYPHS + 1)-1:0]                   n,
    input  logic [utwm_pkg::ADV_W-1:0]                          fallback,
    output utwm_pkg::srch_rsp_t                                 rsp,
    output logic [((MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1)-1:0] rd_addr,
    input  logic [utwm_pkg::ENTRY_W-1:0]                        rd_data
);
    import utwm_pkg::*;

    localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CW = $clog2(MAX_GLYPHS + 1);
    localparam int SW = CW + 1;

    srch_state_t     state_reg, state_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hip1_reg, hip1_next;
    logic [AW-1:0]   mid_reg, mid_next;
    logic [SW-1:0]   mid_sum;
    logic [CW-1:0]   mid_ext;
    logic [CP_W-1:0] rd_code;
    logic [ADV_W-1:0] rd_adv;

    assign rd_code = rd_data[ENTRY_W-1 -: CP_W];
    assign rd_adv  = rd_data[ADV_W-1:0];
    assign mid_ext = CW'(mid_reg);

    // floor((lo + hi) / 2) with hi = hip1 - 1
    assign mid_sum  = SW'(lo_next) + SW'(hip1_next) - SW'(1);
    assign mid_next = AW'(mid_sum >> 1);
    assign rd_addr  = mid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SRCH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        lo_reg   <= lo_next;
        hip1_reg <= hip1_next;
        mid_reg  <= mid_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cp_next    = cp_reg;
        lo_next    = lo_reg;
        hip1_next  = hip1_reg;
        rsp        = '0;
        case (state_reg)
            SRCH_IDLE:
            begin
                if (req.start)
                begin
                    cp_next    = req.codepoint;
                    lo_next    = '0;
                    hip1_next  = n;
                    state_next = (n == '0) ? SRCH_MISS : SRCH_PROBE;
                end
            end
            SRCH_PROBE:
            begin
                if (rd_code == cp_reg)
                begin
                    rsp.done    = 1'b1;
                    rsp.advance = rd_adv;
                    state_next  = SRCH_IDLE;
                end
                else
                begin
                    if (rd_code < cp_reg)
                    begin
                        lo_next = mid_ext + CW'(1);
                    end
                    else
                    begin
                        hip1_next = mid_ext;
                    end
                    if (lo_next >= hip1_next)
                    begin
                        rsp.done    = 1'b1;
                        rsp.advance = fallback;
                        state_next  = SRCH_IDLE;
                    end
                end
            end
            SRCH_MISS:
            begin
                rsp.done    = 1'b1;
                rsp.advance = fallback;
                state_next  = SRCH_IDLE;
            end
            default:
            begin
                state_next = SRCH_IDLE;
            end
        endcase
    end

endmodule

// ===== src/utf8_text_width_measurer_top.sv =====
// UTF-8 text width measurer. Load words (command 0) write one glyph entry
// (codepoint, advance) into the glyph table memory; the table must hold
// glyph_count entries sorted ascending before text is sent. Text words
// (command 1) carry one UTF-8 byte; a byte that completes a codepoint, or
// is a bad lead, starts a binary search of the table that reads one entry
// per cycle from the memory; no new word is taken during the search. A bad
// continuation byte costs one search for U+FFFD, then its own handling as a
// lead byte. An end word (command 2) counts an unfinished sequence as U+FFFD
// (one search), then returns the saturating width and the saturation flag as
// one result word and clears the text state; a new word is accepted while
// that result still waits. The glyph table has no reset and needs no
// clearing pass.
module utf8_text_width_measurer_top #(
    parameter int MAX_GLYPHS = utwm_pkg::MAX_GLYPHS_DEF,
    parameter int WIDTH_BITS = utwm_pkg::WIDTH_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    utwm_item_if.sink     item,
    utwm_result_if.source result,
    utwm_cfg_if.sink      cfg
);
    import utwm_pkg::*;

    localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int CW = $clog2(MAX_GLYPHS + 1);

    ctl_state_t           state_reg, state_next;
    logic [1:0]           bse_reg, bse_next;
    logic [CP_W-1:0]      pcp_reg, pcp_next;
    logic [WIDTH_BITS-1:0] sum_reg, sum_next;
    logic                 ovf_reg, ovf_next;
    logic                 lead_pend_reg, lead_pend_next;
    logic                 emit_pend_reg, emit_pend_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TEXT_W-1:0]    out_width_reg, out_width_next;
    logic                 out_sat_reg, out_sat_next;
    logic [COUNT_W-1:0]   glyph_count_reg;
    logic [ADV_W-1:0]     fallback_reg;

    logic [CW-1:0]        glyph_n;
    srch_req_t            srch_req;
    srch_rsp_t            srch_rsp;
    logic [AW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 wr_en;
    logic                 accept;

    logic [BYTE_W-1:0]    lead_byte;
    logic                 lead_seq;
    logic [CP_W-1:0]      lead_pcp;
    logic [1:0]           lead_bse;
    logic [CP_W-1:0]      lead_cp;
    logic                 is_cont;
    logic [CP_W-1:0]      cont_pcp;
    logic [WIDTH_BITS:0]  sum_wide;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_count_reg <= '0;
            fallback_reg    <= FALLBACK_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_GLYPH_COUNT: glyph_count_reg <= cfg.data[COUNT_W-1:0];
                CFG_FALLBACK:    fallback_reg    <= cfg.data[ADV_W-1:0];
                default:         ;
            endcase
        end
    end

    assign glyph_n = (32'(glyph_count_reg) > 32'(MAX_GLYPHS)) ? CW'(MAX_GLYPHS)
                                                              : CW'(glyph_count_reg);

    // glyph table
    assign accept = item.valid && item.ready;
    assign wr_en  = accept && (item.command == CMD_LOAD)
                    && (32'(item.entry_index) < 32'(MAX_GLYPHS));

    utwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_GLYPHS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(item.entry_index)),
        .wr_data ({item.entry_codepoint, item.entry_advance}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    utwm_search #(
        .MAX_GLYPHS (MAX_GLYPHS)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (srch_req),
        .n        (glyph_n),
        .fallback (fallback_reg),
        .rsp      (srch_rsp),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // byte decode
    assign lead_byte = (state_reg == CTL_LEAD) ? byte_reg : item.text_byte;
    assign is_cont   = (lead_byte & CONT_MASK) == CONT_TAG;
    assign cont_pcp  = {pcp_reg[CP_W-7:0], lead_byte[5:0]};

    always_comb
    begin
        lead_seq = 1'b1;
        lead_pcp = '0;
        lead_bse = 2'd0;
        lead_cp  = REPLACEMENT_CP;
        if (!lead_byte[BYTE_W-1])
        begin
            lead_seq = 1'b0;
            lead_cp  = CP_W'(lead_byte);
        end
        else if ((lead_byte & LEAD2_MASK) == LEAD2_TAG)
        begin
            lead_pcp = CP_W'(lead_byte & LEAD2_BITS);
            lead_bse = 2'd1;
        end
        else if ((lead_byte & LEAD3_MASK) == LEAD3_TAG)
        begin
            lead_pcp = CP_W'(lead_byte & LEAD3_BITS);
            lead_bse = 2'd2;
        end
        else if ((lead_byte & LEAD4_MASK) == LEAD4_TAG)
        begin
            lead_pcp = CP_W'(lead_byte & LEAD4_BITS);
            lead_bse = 2'd3;
        end
        else
        begin
            lead_seq = 1'b0;
        end
    end

    assign sum_wide = {1'b0, sum_reg} + (WIDTH_BITS + 1)'(srch_rsp.advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            bse_reg       <= 2'd0;
            pcp_reg       <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            lead_pend_reg <= 1'b0;
            emit_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bse_reg       <= bse_next;
            pcp_reg       <= pcp_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            lead_pend_reg <= lead_pend_next;
            emit_pend_reg <= emit_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        out_width_reg <= out_width_next;
        out_sat_reg   <= out_sat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        bse_next       = bse_reg;
        pcp_next       = pcp_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        lead_pend_next = lead_pend_reg;
        emit_pend_next = emit_pend_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_width_next = out_width_reg;
        out_sat_next   = out_sat_reg;
        srch_req       = '0;
        item.ready     = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    case (item.command)
                        CMD_BYTE:
                        begin
                            if (bse_reg != 2'd0)
                            begin
                                if (is_cont)
                                begin
                                    pcp_next = cont_pcp;
                                    bse_next = bse_reg - 2'd1;
                                    if (bse_reg == 2'd1)
                                    begin
                                        srch_req.start     = 1'b1;
                                        srch_req.codepoint = cont_pcp;
                                        state_next         = CTL_WAIT;
                                    end
                                end
                                else
                                begin
                                    // broken sequence, then retry byte as lead
                                    srch_req.start     = 1'b1;
                                    srch_req.codepoint = REPLACEMENT_CP;
                                    bse_next           = 2'd0;
                                    pcp_next           = '0;
                                    byte_next          = item.text_byte;
                                    lead_pend_next     = 1'b1;
                                    state_next         = CTL_WAIT;
                                end
                            end
                            else if (lead_seq)
                            begin
                                pcp_next = lead_pcp;
                                bse_next = lead_bse;
                            end
                            else
                            begin
                                srch_req.start     = 1'b1;
                                srch_req.codepoint = lead_cp;
                                state_next         = CTL_WAIT;
                            end
                        end
                        CMD_END:
                        begin
                            if (bse_reg != 2'd0)
                            begin
                                srch_req.start     = 1'b1;
                                srch_req.codepoint = REPLACEMENT_CP;
                                emit_pend_next     = 1'b1;
                                state_next         = CTL_WAIT;
                            end
                            else
                            begin
                                state_next = CTL_EMIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CTL_WAIT:
            begin
                if (srch_rsp.done)
                begin
                    if (sum_wide[WIDTH_BITS])
                    begin
                        sum_next = '1;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_wide[WIDTH_BITS-1:0];
                    end
                    if (lead_pend_reg)
                    begin
                        lead_pend_next = 1'b0;
                        state_next     = CTL_LEAD;
                    end
                    else if (emit_pend_reg)
                    begin
                        emit_pend_next = 1'b0;
                        state_next     = CTL_EMIT;
                    end
                    else
                    begin
                        state_next = CTL_IDLE;
                    end
                end
            end
            CTL_LEAD:
            begin
                if (lead_seq)
                begin
                    pcp_next   = lead_pcp;
                    bse_next   = lead_bse;
                    state_next = CTL_IDLE;
                end
                else
                begin
                    srch_req.start     = 1'b1;
                    srch_req.codepoint = lead_cp;
                    state_next         = CTL_WAIT;
                end
            end
            CTL_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_width_next = TEXT_W'(sum_reg);
                    out_sat_next   = ovf_reg;
                    sum_next       = '0;
                    ovf_next       = 1'b0;
                    bse_next       = 2'd0;
                    pcp_next       = '0;
                    state_next     = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    assign result.valid           = out_valid_reg;
    assign result.text_width      = out_width_reg;
    assign result.width_saturated = out_sat_reg;

endmodule

// ===== src/utwm_checker.sv =====
`include "utf8_text_width_measurer_top_defines.svh"

module utwm_checker #(
    parameter int WIDTH_BITS = utwm_pkg::WIDTH_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic [utwm_pkg::CMD_W-1:0]   item_command,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [utwm_pkg::TEXT_W-1:0]  result_text_width,
    input logic                         result_width_saturated
);
    import utwm_pkg::*;

    localparam logic [63:0]       CEIL     = (64'd1 << WIDTH_BITS) - 64'd1;
    localparam logic [TEXT_W-1:0] SAT_TEXT = CEIL[TEXT_W-1:0];

    `UTWM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(result_text_width) && $stable(result_width_saturated),
        "stalled result word changed")
    `UTWM_ASSERT_NOW(a_sat_ceiling, clk, rst_n, result_valid && result_width_saturated,
        result_text_width == SAT_TEXT, "saturated width below ceiling")
    `UTWM_ASSERT_NOW(a_emit_no_take, clk, rst_n, $rose(result_valid),
        !$past(item_ready), "result emitted while taking input")
    `UTWM_ASSERT_NEXT(a_end_busy, clk, rst_n, item_valid && item_ready && item_command == CMD_END,
        !item_ready, "input taken right after end word")
    `UTWM_ASSERT_NEXT(a_load_fast, clk, rst_n,
        item_valid && item_ready && item_command != CMD_BYTE && item_command != CMD_END,
        item_ready, "load word not finished in one cycle")

endmodule

bind utf8_text_width_measurer_top utwm_checker #(
    .WIDTH_BITS (WIDTH_BITS)
) u_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .item_valid             (item.valid),
    .item_ready             (item.ready),
    .item_command           (item.command),
    .result_valid           (result.valid),
    .result_ready           (result.ready),
    .result_text_width      (result.text_width),
    .result_width_saturated (result.width_saturated)
);

// ===== tb/utwm_width_checker.sv =====
module utwm_width_checker (
    input  logic   clk,
    input  logic   rst_n,
    utwm_item_if   item,
    utwm_result_if result,
    utwm_cfg_if    cfg,
    output int     mismatches,
    output int     widths_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import utwm_pkg::*;

    localparam int unsigned WIDTH_CEIL = (1 << WIDTH_BITS_DEF) - 1;

    typedef struct packed {
        logic [TEXT_W-1:0] width;
        logic              saturated;
    } width_word_t;

    width_word_t        widths_due[$];

    logic [CP_W-1:0]    code_mem [MAX_GLYPHS_DEF];
    logic [ADV_W-1:0]   adv_mem  [MAX_GLYPHS_DEF];
    logic [COUNT_W-1:0] glyph_count;
    logic [ADV_W-1:0]   fallback_adv;

    int unsigned        cont_left;
    logic [CP_W-1:0]    partial_cp;
    int unsigned        width_acc;
    logic               width_ovf;

    // binary search over the live part of the table, midpoint rounds down
    function automatic logic [ADV_W-1:0] glyph_advance(input logic [CP_W-1:0] cp);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = ((glyph_count > COUNT_W'(MAX_GLYPHS_DEF)) ? MAX_GLYPHS_DEF
                                                       : int'(glyph_count)) - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (code_mem[mid] < cp)
                lo = mid + 1;
            else if (code_mem[mid] > cp)
                hi = mid - 1;
            else
                return adv_mem[mid];
        end
        return fallback_adv;
    endfunction

    function automatic void add_glyph(input logic [CP_W-1:0] cp);
        int unsigned s;
        s = width_acc + int'(glyph_advance(cp));
        if (s > WIDTH_CEIL)
        begin
            s = WIDTH_CEIL;
            width_ovf = 1'b1;
        end
        width_acc = s;
    endfunction

    function automatic void take_lead(input logic [BYTE_W-1:0] b);
        if (!b[BYTE_W-1])
            add_glyph(CP_W'(b));
        else if ((b & LEAD2_MASK) == LEAD2_TAG)
        begin
            partial_cp = CP_W'(b & LEAD2_BITS);
            cont_left = 1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG)
        begin
            partial_cp = CP_W'(b & LEAD3_BITS);
            cont_left = 2;
        end
        else if ((b & LEAD4_MASK) == LEAD4_TAG)
        begin
            partial_cp = CP_W'(b & LEAD4_BITS);
            cont_left = 3;
        end
        else
            add_glyph(REPLACEMENT_CP);
    endfunction

    function automatic void take_text_byte(input logic [BYTE_W-1:0] b);
        if (cont_left != 0)
        begin
            if ((b & CONT_MASK) == CONT_TAG)
            begin
                partial_cp = (partial_cp << 6) | CP_W'(b & CONT_BITS);
                cont_left--;
                if (cont_left == 0)
                    add_glyph(partial_cp);
                return;
            end
            // broken sequence: count it, then reread the byte as a lead
            add_glyph(REPLACEMENT_CP);
            cont_left = 0;
            partial_cp = '0;
        end
        take_lead(b);
    endfunction

    function automatic void flag_word(input string what, input width_word_t want,
                                      input width_word_t got);
        if (mismatches < 10)
            $display("[%0t] width word %s: expected width=%0d sat=%0b, got width=%0d sat=%0b",
                     $time, what, want.width, want.saturated, got.width, got.saturated);
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        width_word_t got;
        width_word_t want;
        if (!rst_n)
        begin
            cont_left    = 0;
            partial_cp   = '0;
            width_acc    = 0;
            width_ovf    = 1'b0;
            glyph_count  = '0;
            fallback_adv = FALLBACK_RESET;
            widths_due.delete();
            mismatches   = 0;
            widths_owed  = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.width     = result.text_width;
                got.saturated = result.width_saturated;
                if (widths_due.size() == 0)
                    flag_word("with none pending", '0, got);
                else
                begin
                    want = widths_due.pop_front();
                    if (got.width != want.width || got.saturated != want.saturated)
                        flag_word("mismatch", want, got);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_GLYPH_COUNT: glyph_count  = cfg.data[COUNT_W-1:0];
                    CFG_FALLBACK:    fallback_adv = cfg.data[ADV_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                case (item.command)
                    CMD_LOAD:
                    begin
                        code_mem[item.entry_index] = item.entry_codepoint;
                        adv_mem[item.entry_index]  = item.entry_advance;
                    end
                    CMD_BYTE: take_text_byte(item.text_byte);
                    CMD_END:
                    begin
                        if (cont_left != 0)
                            add_glyph(REPLACEMENT_CP);
                        want.width     = width_acc[TEXT_W-1:0];
                        want.saturated = width_ovf;
                        widths_due.push_back(want);
                        cont_left  = 0;
                        partial_cp = '0;
                        width_acc  = 0;
                        width_ovf  = 1'b0;
                    end
                    default: ;
                endcase
            end
            widths_owed = widths_due.size();
        end
    end

endmodule

// ===== tb/tb_utf8_text_width_measurer_top.sv =====
module tb_utf8_text_width_measurer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import utwm_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B  = 2'd3;
    localparam int                   DRAIN_CYCLES = 40;
    localparam int                   HOLD_CYCLES  = 400;
    localparam int                   CP_SPAN      = 1 << CP_W;

    logic clk;
    logic rst_n;

    int   mismatches;
    int   widths_owed;
    int   src_idle_pct;
    int   snk_stall_pct;
    bit   hold_off_req;
    int   words_sent;
    int   active_glyphs;

    logic [CP_W-1:0] tbl_cp [MAX_GLYPHS_DEF];

    utwm_item_if   item_ch ();
    utwm_result_if result_ch ();
    utwm_cfg_if    cfg_ch ();

    utf8_text_width_measurer_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    utwm_width_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .widths_owed (widths_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ch.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                             input logic [CP_W-1:0] cp, input logic [ADV_W-1:0] adv,
                             input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid           = 1'b1;
        item_ch.command         = cmd;
        item_ch.entry_index     = idx;
        item_ch.entry_codepoint = cp;
        item_ch.entry_advance   = adv;
        item_ch.text_byte       = b;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic load_entry(input int slot, input logic [CP_W-1:0] cp,
                              input logic [ADV_W-1:0] adv);
        send_word(CMD_LOAD, INDEX_W'(slot), cp, adv, BYTE_W'($urandom()));
        tbl_cp[slot] = cp;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_word(CMD_BYTE, INDEX_W'($urandom()), CP_W'($urandom()), ADV_W'($urandom()), b);
    endtask

    task automatic end_text();
        send_word(CMD_END, INDEX_W'($urandom()), CP_W'($urandom()), ADV_W'($urandom()),
                  BYTE_W'($urandom()));
    endtask

    task automatic write_pair(input logic [CFG_IDX_W-1:0] idx_a, input logic [CFG_DATA_W-1:0] val_a,
                              input logic [CFG_IDX_W-1:0] idx_b, input logic [CFG_DATA_W-1:0] val_b);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx_a;
        cfg_ch.data  = val_a;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.index = idx_b;
        cfg_ch.data  = val_b;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        item_ch.valid = 1'b0;
        while (widths_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic start_phase(input int src_pct, input int snk_pct,
                               input logic [CFG_DATA_W-1:0] count,
                               input logic [CFG_DATA_W-1:0] fb);
        drain();
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        write_pair(CFG_GLYPH_COUNT, count, CFG_FALLBACK, fb);
        active_glyphs = (int'(count) > MAX_GLYPHS_DEF) ? MAX_GLYPHS_DEF : int'(count);
    endtask

    task automatic load_sorted(input int n);
        int step;
        step = CP_SPAN / n;
        for (int i = 0; i < n; i++)
            load_entry(i, CP_W'(i * step + int'($urandom_range(step - 1))), ADV_W'($urandom()));
    endtask

    task automatic load_scattered(input int n);
        for (int i = 0; i < n; i++)
            load_entry(i, $urandom_range(1) ? CP_W'($urandom_range(127))
                                            : CP_W'($urandom_range(CP_SPAN - 1)),
                       ADV_W'($urandom()));
    endtask

    // UTF-8 encode cp in len bytes (len may be overlong), send the first cut bytes
    task automatic send_char(input logic [CP_W-1:0] cp, input int len, input int cut);
        logic [BYTE_W-1:0] seq [4];
        case (len)
            1: seq[0] = BYTE_W'(cp);
            2: seq[0] = LEAD2_TAG | (BYTE_W'(cp >> 6) & LEAD2_BITS);
            3: seq[0] = LEAD3_TAG | (BYTE_W'(cp >> 12) & LEAD3_BITS);
            default: seq[0] = LEAD4_TAG | (BYTE_W'(cp >> 18) & LEAD4_BITS);
        endcase
        for (int k = 1; k < len; k++)
            seq[k] = CONT_TAG | (BYTE_W'(cp >> (6 * (len - 1 - k))) & CONT_BITS);
        for (int k = 0; k < cut; k++)
            send_byte(seq[k]);
    endtask

    task automatic emit_char(input bit truncate);
        int              r;
        int              need;
        int              len;
        logic [CP_W-1:0] cp;
        r = $urandom_range(99);
        if (r < 55 && active_glyphs > 0)
            cp = tbl_cp[$urandom_range(active_glyphs - 1)];
        else if (r < 80)
            cp = CP_W'($urandom_range(127));
        else
            cp = CP_W'($urandom_range(CP_SPAN - 1));
        need = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        len = ($urandom_range(99) < 15) ? int'($urandom_range(4, need)) : need;
        if (truncate)
        begin
            if (len == 1)
                len = $urandom_range(4, 2);
            send_char(cp, len, $urandom_range(len - 1, 1));
        end
        else
            send_char(cp, len, len);
    endtask

    task automatic run_text(input int n);
        int stop;
        int r;
        int slot;
        stop = words_sent + n;
        while (words_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 62)
                emit_char(1'b0);
            else if (r < 70)
                emit_char(1'b1);
            else if (r < 77)
                send_byte(BYTE_W'($urandom_range(255)));
            else if (r < 80)
                send_byte(CONT_TAG | BYTE_W'($urandom_range(63)));
            else if (r < 91)
                end_text();
            else if (r < 97 && active_glyphs > 0)
            begin
                slot = $urandom_range(active_glyphs - 1);
                load_entry(slot, tbl_cp[slot], ADV_W'($urandom()));
            end
            else
                send_word(CMD_SPARE, INDEX_W'($urandom()), CP_W'($urandom()),
                          ADV_W'($urandom()), BYTE_W'($urandom()));
        end
        end_text();
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        item_ch.valid           = 1'b0;
        item_ch.command         = CMD_LOAD;
        item_ch.entry_index     = '0;
        item_ch.entry_codepoint = '0;
        item_ch.entry_advance   = '0;
        item_ch.text_byte       = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = CFG_GLYPH_COUNT;
        cfg_ch.data             = '0;
        src_idle_pct            = 0;
        snk_stall_pct           = 0;
        hold_off_req            = 1'b0;
        words_sent              = 0;
        active_glyphs           = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unused register slots must be ignored
        drain();
        write_pair(CFG_SPARE_A, '1, CFG_SPARE_B, 11'h2AA);

        // directed: tiny sorted table, upper data bits of fallback ignored
        start_phase(0, 0, 11'd4, 11'h709);
        load_entry(0, '0, 8'd0);
        load_entry(1, 21'h41, 8'd255);
        load_entry(2, REPLACEMENT_CP, 8'd7);
        load_entry(3, '1, 8'd200);
        send_byte(8'h00);
        send_byte(8'h41);
        send_byte(8'h7F);
        send_char('1, 4, 4);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hC3);
        send_byte(8'h41);
        send_char(21'h20AC, 3, 3);
        end_text();
        send_byte(8'hE2);
        end_text();
        send_word(CMD_SPARE, '1, '1, '1, '1);

        // empty table, widest fallback: drive the sum into saturation
        start_phase(52, 0, 11'd0, 11'h0FF);
        for (int i = 0; i < 262; i++)
            send_byte(BYTE_W'($urandom_range(127)));
        end_text();
        run_text(40);

        // full sorted table, count above the table size; long result hold-off
        start_phase(0, 52, '1, 11'h700);
        load_sorted(MAX_GLYPHS_DEF);
        hold_off_req = 1'b1;
        repeat (3) emit_char(1'b0);
        end_text();
        repeat (3) emit_char(1'b0);
        end_text();
        end_text();
        end_text();
        run_text(150);

        // unsorted table
        start_phase(24, 24, 11'd13, CFG_DATA_W'($urandom()));
        load_scattered(13);
        run_text(100);

        start_phase(0, 0, 11'd1, CFG_DATA_W'($urandom()));
        load_sorted(1);
        run_text(100);

        // count exactly the table size, mixed leftovers from earlier loads
        start_phase(52, 0, CFG_DATA_W'(MAX_GLYPHS_DEF), CFG_DATA_W'($urandom()));
        run_text(100);

        start_phase(0, 52, CFG_DATA_W'($urandom_range(64, 2)), CFG_DATA_W'($urandom()));
        load_sorted(active_glyphs);
        run_text(120);

        drain();
        if (mismatches == 0 && widths_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
